### hdl/password_lock_controller_top_assert.svh
// Assertion macros shared by the lock controller modules.
// Each expects clk and rst_n in scope.
`ifndef PASSWORD_LOCK_CONTROLLER_TOP_ASSERT_SVH
`define PASSWORD_LOCK_CONTROLLER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PLC_ASSERT(lbl, prop, msg)
`define PLC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/plc_pkg.sv
`timescale 1ns / 1ps

package plc_pkg;

  localparam int CODE_LEN = 5;
  localparam int IDX_W    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_LEN - 1);

  // configuration register indexes
  localparam logic [2:0] CFG_ENTER_KEY  = 3'd0;
  localparam logic [2:0] CFG_OPEN_CHC   = 3'd1;
  localparam logic [2:0] CFG_CHANGE_CHC = 3'd2;
  localparam logic [2:0] CFG_MAX_TRIALS = 3'd3;
  localparam logic [2:0] CFG_OPEN_SEC   = 3'd4;
  localparam logic [2:0] CFG_HOLD_SEC   = 3'd5;
  localparam logic [2:0] CFG_CLOSE_SEC  = 3'd6;
  localparam logic [2:0] CFG_ALARM_SEC  = 3'd7;

  localparam logic [1:0] RPL_MATCHED   = 2'd0;
  localparam logic [1:0] RPL_UNMATCHED = 2'd1;
  localparam logic [1:0] RPL_WRONG_CNF = 2'd2;
  localparam logic [1:0] RPL_EXHAUSTED = 2'd3;

  localparam logic [1:0] MOTOR_STOP = 2'd0;
  localparam logic [1:0] MOTOR_CW   = 2'd1;
  localparam logic [1:0] MOTOR_ACW  = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       reply_valid;
    logic [1:0] reply_code;
    logic [1:0] motor_drive;
    logic       buzzer_active;
  } out_item_t;

  typedef struct packed {
    logic [7:0] enter_key_code;
    logic [7:0] open_choice_code;
    logic [7:0] change_choice_code;
    logic [1:0] max_trials;
    logic [7:0] alarm_seconds;
  } entry_cfg_t;

  typedef struct packed {
    logic [7:0] open_seconds;
    logic [7:0] hold_seconds;
    logic [7:0] close_seconds;
  } door_cfg_t;

  typedef struct packed {
    logic       reply_valid;
    logic [1:0] reply_code;
    logic       alarm_on;
    logic       door_open;
  } entry_rsp_t;

endpackage

### hdl/plc_stream_if.sv
`timescale 1ns / 1ps

interface plc_in_if;
  logic               valid;
  logic               ready;
  plc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface plc_out_if;
  logic               valid;
  logic               ready;
  plc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/password_lock_controller_top.sv
`timescale 1ns / 1ps
`include "password_lock_controller_top_assert.svh"

// channel  dir  payload                                             beat
// in_s     in   cmd, rx_byte                                        valid && ready
// out_s    out  reply_valid, reply_code, motor_drive, buzzer_active valid && ready
// cfg_*    in   cfg_idx, cfg_wdata                                  cfg_we
//
// One item per cycle while out_s does not stall; each accepted beat yields one registered result beat.
// Entry, alarm and door state update at the accepting edge; the result sits in
// a single output register, so in_s.ready drops only while that register is
// full and out_s.ready is low.
// Synchronous active-low reset: password setting, door idle, defaults loaded.

module password_lock_controller_top (
  input  logic              clk,
  input  logic              rst_n,
  plc_in_if.sink            in_s,
  plc_out_if.source         out_s,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [7:0]        cfg_wdata
);

  plc_pkg::entry_cfg_t entry_cfg_r;
  plc_pkg::door_cfg_t  door_cfg_r;
  plc_pkg::entry_rsp_t rsp;
  plc_pkg::out_item_t  out_data_r;
  logic                out_valid_r;
  logic                beat;
  logic [1:0]          motor_drive;

  assign in_s.ready = !out_valid_r || out_s.ready;
  assign beat       = in_s.valid && in_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_cfg_r.enter_key_code     <= 8'd13;
      entry_cfg_r.open_choice_code   <= 8'd43;
      entry_cfg_r.change_choice_code <= 8'd45;
      entry_cfg_r.max_trials         <= 2'd3;
      door_cfg_r.open_seconds        <= 8'd15;
      door_cfg_r.hold_seconds        <= 8'd3;
      door_cfg_r.close_seconds       <= 8'd15;
      entry_cfg_r.alarm_seconds      <= 8'd60;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        plc_pkg::CFG_ENTER_KEY:  entry_cfg_r.enter_key_code     <= cfg_wdata;
        plc_pkg::CFG_OPEN_CHC:   entry_cfg_r.open_choice_code   <= cfg_wdata;
        plc_pkg::CFG_CHANGE_CHC: entry_cfg_r.change_choice_code <= cfg_wdata;
        plc_pkg::CFG_MAX_TRIALS: entry_cfg_r.max_trials         <= cfg_wdata[1:0];
        plc_pkg::CFG_OPEN_SEC:   door_cfg_r.open_seconds        <= cfg_wdata;
        plc_pkg::CFG_HOLD_SEC:   door_cfg_r.hold_seconds        <= cfg_wdata;
        plc_pkg::CFG_CLOSE_SEC:  door_cfg_r.close_seconds       <= cfg_wdata;
        plc_pkg::CFG_ALARM_SEC:  entry_cfg_r.alarm_seconds      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  plc_entry u_entry (
    .clk   (clk),
    .rst_n (rst_n),
    .beat  (beat),
    .item  (in_s.data),
    .cfg   (entry_cfg_r),
    .rsp   (rsp)
  );

  plc_door u_door (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (beat && in_s.data.cmd),
    .start_open  (rsp.door_open),
    .cfg         (door_cfg_r),
    .motor_drive (motor_drive)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      out_data_r.reply_valid   <= rsp.reply_valid;
      out_data_r.reply_code    <= rsp.reply_code;
      out_data_r.motor_drive   <= motor_drive;
      out_data_r.buzzer_active <= rsp.alarm_on;
    end
  end

  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_data_r;

  `PLC_ASSERT_NEXT(a_beat_gives_result, beat, out_valid_r, "accepted beat produced no result")

endmodule

### hdl/plc_door.sv
`timescale 1ns / 1ps
`include "password_lock_controller_top_assert.svh"

module plc_door (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tick,
  input  logic               start_open,
  input  plc_pkg::door_cfg_t cfg,
  output logic [1:0]         motor_drive
);

  localparam logic [1:0] D_IDLE  = 2'd0;
  localparam logic [1:0] D_OPEN  = 2'd1;
  localparam logic [1:0] D_HOLD  = 2'd2;
  localparam logic [1:0] D_CLOSE = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] timer_r, timer_nxt;

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    if (start_open) begin
      // restarts opening even while the door is moving
      phase_nxt = D_OPEN;
      timer_nxt = cfg.open_seconds;
    end else if (tick && phase_r != D_IDLE) begin
      if (timer_r > 8'd1) begin
        timer_nxt = timer_r - 8'd1;
      end else begin
        unique case (phase_r)
          D_OPEN: begin
            phase_nxt = D_HOLD;
            timer_nxt = cfg.hold_seconds;
          end
          D_HOLD: begin
            phase_nxt = D_CLOSE;
            timer_nxt = cfg.close_seconds;
          end
          D_CLOSE: begin
            phase_nxt = D_IDLE;
            timer_nxt = 8'd0;
          end
          default: begin
            phase_nxt = D_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (phase_nxt)
      D_OPEN:  motor_drive = plc_pkg::MOTOR_CW;
      D_CLOSE: motor_drive = plc_pkg::MOTOR_ACW;
      default: motor_drive = plc_pkg::MOTOR_STOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= D_IDLE;
      timer_r <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
    end
  end

  `PLC_ASSERT_NEXT(a_open_starts, start_open, phase_r == D_OPEN, "open request did not start opening")

endmodule

### hdl/plc_entry.sv
`timescale 1ns / 1ps
`include "password_lock_controller_top_assert.svh"

module plc_entry (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                beat,
  input  plc_pkg::in_item_t   item,
  input  plc_pkg::entry_cfg_t cfg,
  output plc_pkg::entry_rsp_t rsp
);

  localparam logic [3:0] M_SET1       = 4'd0;
  localparam logic [3:0] M_SET1_WAIT  = 4'd1;
  localparam logic [3:0] M_SET2       = 4'd2;
  localparam logic [3:0] M_SET2_WAIT  = 4'd3;
  localparam logic [3:0] M_MENU       = 4'd4;
  localparam logic [3:0] M_LOGIN      = 4'd5;
  localparam logic [3:0] M_LOGIN_WAIT = 4'd6;
  localparam logic [3:0] M_ALARM_MENU = 4'd7;
  localparam logic [3:0] M_ALARM_SET  = 4'd8;

  logic [3:0]               mode_r, mode_nxt;
  logic [plc_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                     differs_r, differs_nxt;
  logic                     purpose_r, purpose_nxt;
  logic [1:0]               login_fail_r, login_fail_nxt;
  logic [1:0]               conf_fail_r, conf_fail_nxt;
  logic [7:0]               alarm_timer_r, alarm_timer_nxt;
  logic [7:0]               saved_r [plc_pkg::CODE_LEN];
  logic [7:0]               first_r [plc_pkg::CODE_LEN];

  logic       tick, byte_beat, last_digit, mismatch, is_enter;
  logic       wr_first, copy_saved;
  logic [7:0] ref_digit;
  logic [1:0] login_bump, conf_bump;

  assign tick       = beat && item.cmd;
  assign byte_beat  = beat && !item.cmd;
  assign last_digit = (idx_r == plc_pkg::LAST_IDX);
  assign ref_digit  = (mode_r == M_SET2) ? first_r[idx_r] : saved_r[idx_r];
  assign mismatch   = (ref_digit != item.rx_byte);
  assign is_enter   = (item.rx_byte == cfg.enter_key_code);
  assign login_bump = (login_fail_r == 2'd3) ? 2'd3 : login_fail_r + 2'd1;
  assign conf_bump  = (conf_fail_r == 2'd3) ? 2'd3 : conf_fail_r + 2'd1;

  always_comb begin
    mode_nxt        = mode_r;
    idx_nxt         = idx_r;
    differs_nxt     = differs_r;
    purpose_nxt     = purpose_r;
    login_fail_nxt  = login_fail_r;
    conf_fail_nxt   = conf_fail_r;
    alarm_timer_nxt = alarm_timer_r;
    wr_first        = 1'b0;
    copy_saved      = 1'b0;
    rsp             = '0;

    if (tick) begin
      if (mode_r == M_ALARM_MENU || mode_r == M_ALARM_SET) begin
        if (alarm_timer_r > 8'd1) begin
          alarm_timer_nxt = alarm_timer_r - 8'd1;
        end else begin
          alarm_timer_nxt = 8'd0;
          if (mode_r == M_ALARM_MENU) begin
            mode_nxt = M_MENU;
          end else begin
            mode_nxt    = M_SET1;
            idx_nxt     = '0;
            differs_nxt = 1'b0;
          end
        end
      end
    end else if (byte_beat) begin
      unique case (mode_r)
        M_SET1, M_SET2, M_LOGIN: begin
          // every byte is a digit here, the enter key included
          wr_first = (mode_r == M_SET1);
          if (mode_r != M_SET1 && mismatch) differs_nxt = 1'b1;
          if (last_digit) begin
            idx_nxt  = '0;
            mode_nxt = mode_r + 4'd1;
          end else begin
            idx_nxt = idx_r + plc_pkg::IDX_W'(1);
          end
        end
        M_SET1_WAIT: begin
          if (is_enter) begin
            mode_nxt    = M_SET2;
            idx_nxt     = '0;
            differs_nxt = 1'b0;
          end
        end
        M_SET2_WAIT: begin
          if (is_enter) begin
            rsp.reply_valid = 1'b1;
            if (!differs_r) begin
              rsp.reply_code = plc_pkg::RPL_MATCHED;
              copy_saved     = 1'b1;
              conf_fail_nxt  = 2'd0;
              mode_nxt       = M_MENU;
            end else begin
              conf_fail_nxt = conf_bump;
              if (conf_bump >= cfg.max_trials) begin
                rsp.reply_code  = plc_pkg::RPL_EXHAUSTED;
                mode_nxt        = M_ALARM_SET;
                alarm_timer_nxt = cfg.alarm_seconds;
              end else begin
                rsp.reply_code = plc_pkg::RPL_WRONG_CNF;
                mode_nxt       = M_SET1;
                idx_nxt        = '0;
                differs_nxt    = 1'b0;
              end
            end
          end
        end
        M_MENU: begin
          // open wins when both choice codes are equal
          if (item.rx_byte == cfg.open_choice_code) begin
            purpose_nxt = 1'b0;
            mode_nxt    = M_LOGIN;
            idx_nxt     = '0;
            differs_nxt = 1'b0;
          end else if (item.rx_byte == cfg.change_choice_code) begin
            purpose_nxt = 1'b1;
            mode_nxt    = M_LOGIN;
            idx_nxt     = '0;
            differs_nxt = 1'b0;
          end
        end
        M_LOGIN_WAIT: begin
          if (is_enter) begin
            rsp.reply_valid = 1'b1;
            if (!differs_r) begin
              rsp.reply_code = plc_pkg::RPL_MATCHED;
              login_fail_nxt = 2'd0;
              if (!purpose_r) begin
                rsp.door_open = 1'b1;
                mode_nxt      = M_MENU;
              end else begin
                mode_nxt    = M_SET1;
                idx_nxt     = '0;
                differs_nxt = 1'b0;
              end
            end else if (login_bump >= cfg.max_trials) begin
              rsp.reply_code  = plc_pkg::RPL_EXHAUSTED;
              login_fail_nxt  = 2'd0;
              mode_nxt        = M_ALARM_MENU;
              alarm_timer_nxt = cfg.alarm_seconds;
            end else begin
              rsp.reply_code = plc_pkg::RPL_UNMATCHED;
              login_fail_nxt = login_bump;
              mode_nxt       = M_MENU;
            end
          end
        end
        default: begin
          // alarm modes and unused codes ignore bytes
        end
      endcase
    end

    rsp.alarm_on = (mode_nxt == M_ALARM_MENU || mode_nxt == M_ALARM_SET);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= M_SET1;
      idx_r         <= '0;
      differs_r     <= 1'b0;
      purpose_r     <= 1'b0;
      login_fail_r  <= 2'd0;
      conf_fail_r   <= 2'd0;
      alarm_timer_r <= 8'd0;
    end else begin
      mode_r        <= mode_nxt;
      idx_r         <= idx_nxt;
      differs_r     <= differs_nxt;
      purpose_r     <= purpose_nxt;
      login_fail_r  <= login_fail_nxt;
      conf_fail_r   <= conf_fail_nxt;
      alarm_timer_r <= alarm_timer_nxt;
    end
  end

  // code stores: no reset, contents undefined until written
  always_ff @(posedge clk) begin
    if (wr_first) first_r[idx_r] <= item.rx_byte;
    if (copy_saved) saved_r <= first_r;
  end

  `PLC_ASSERT(a_idx_range, idx_r <= plc_pkg::LAST_IDX, "digit index past code length")
  `PLC_ASSERT(a_reply_on_byte, !(rsp.reply_valid && !byte_beat), "reply without a byte beat")
  `PLC_ASSERT_NEXT(a_alarm_ignores_bytes,
    byte_beat && (mode_r == M_ALARM_MENU || mode_r == M_ALARM_SET),
    $stable(mode_r) && $stable(alarm_timer_r), "byte disturbed the alarm")

endmodule
